// ===== hw/rtl/isaac_pkg.sv =====
// ----------------------------------------------------------------------------
// isaac_pkg - shared types and constants of the ISAAC generator
// State size, golden-ratio start value, datapath operations and the
// command word that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package isaac_pkg;

  localparam int STATE_WORDS = 256;
  localparam int IDX_W       = $clog2(STATE_WORDS);
  localparam int CNT_W       = IDX_W + 1;
  localparam logic [31:0] GOLDEN = 32'h9e3779b9;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_CAPTURE,
    OP_SEED_WR,
    OP_V_INIT,
    OP_SCRAMBLE,
    OP_LOAD,
    OP_V_WR,
    OP_RF_START,
    OP_RF0,
    OP_RF1,
    OP_RF2,
    OP_RF3,
    OP_RF4,
    OP_REQ_RD,
    OP_OUT_LOAD
  } ip_op_t;

  typedef struct packed {
    ip_op_t           op;
    logic [IDX_W-1:0] addr;
    logic [2:0]       ln;
    logic             rd_en;
    logic             add_en;
    logic             src_mem;
  } ip_cmd_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEED_WR,
    ST_V_INIT,
    ST_MIX,
    ST_LOAD,
    ST_BSCR,
    ST_VWR,
    ST_RF_START,
    ST_RF0,
    ST_RF1,
    ST_RF2,
    ST_RF3,
    ST_RF4,
    ST_REQ_RD,
    ST_REQ_OUT
  } ip_state_t;

  function automatic logic [31:0] scr_shift(input logic [2:0] ln, input logic [31:0] val);
    logic [31:0] res;
    unique case (ln)
      3'd0: res = val << 11;
      3'd1: res = val >> 2;
      3'd2: res = val << 8;
      3'd3: res = val >> 16;
      3'd4: res = val << 10;
      3'd5: res = val >> 4;
      3'd6: res = val << 8;
      3'd7: res = val >> 9;
      default: res = val;
    endcase
    return res;
  endfunction

endpackage

// ===== hw/rtl/ip_ram.sv =====
// ----------------------------------------------------------------------------
// ip_ram - generic single-write, single-read RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module ip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/ip_dp.sv =====
// ----------------------------------------------------------------------------
// ip_dp - ISAAC datapath
// Holds the mixing memory, the result pool, the eight scramble lanes, the
// accumulators and the output register, and carries out one command a cycle.
// ----------------------------------------------------------------------------
module ip_dp (
  input  logic              clk,
  input  isaac_pkg::ip_cmd_t cmd,
  input  logic [31:0]       word_in,
  output logic [31:0]       rand_value
);
  import isaac_pkg::*;

  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] w [8];
  logic [31:0] a_r, a_nxt, b_r, b_nxt, cnt_r, cnt_nxt;
  logic [31:0] x_r, x_nxt, s_r, s_nxt, y_r, y_nxt, word_r, word_nxt, out_r, out_nxt;
  logic        byp_r, byp_nxt;
  logic [31:0] t, y_calc, a_calc, b_calc, ld_data;

  logic             mem_we, mem_re, pool_we, pool_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr, pool_waddr, pool_raddr;
  logic [31:0]      mem_wdata, mem_rdata, pool_wdata, pool_rdata;

  ip_ram #(.WIDTH(32), .DEPTH(STATE_WORDS)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  ip_ram #(.WIDTH(32), .DEPTH(STATE_WORDS)) u_pool (
    .clk(clk), .we(pool_we), .waddr(pool_waddr), .wdata(pool_wdata),
    .re(pool_re), .raddr(pool_raddr), .rdata(pool_rdata)
  );

  always_comb begin
    unique case (cmd.addr[1:0])
      2'd0: t = a_r << 13;
      2'd1: t = a_r >> 6;
      2'd2: t = a_r << 2;
      default: t = a_r >> 16;
    endcase
    a_calc  = (a_r ^ t) + mem_rdata;
    y_calc  = s_r + a_calc;
    b_calc  = (byp_r ? y_r : mem_rdata) + x_r;
    ld_data = cmd.src_mem ? mem_rdata : pool_rdata;

    w[0] = v_r[0] ^ scr_shift(cmd.ln, v_r[1]);
    w[1] = v_r[1] + v_r[2];
    w[2] = v_r[2];
    w[3] = v_r[3] + w[0];
    for (int e = 4; e < 8; e++) begin
      w[e] = v_r[e];
    end

    for (int e = 0; e < 8; e++) begin
      v_nxt[e] = v_r[e];
    end
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    s_nxt    = s_r;
    y_nxt    = y_r;
    byp_nxt  = byp_r;
    word_nxt = word_r;
    out_nxt  = out_r;

    mem_we     = 1'b0;
    mem_waddr  = cmd.addr;
    mem_wdata  = 32'd0;
    mem_re     = 1'b0;
    mem_raddr  = cmd.addr;
    pool_we    = 1'b0;
    pool_waddr = cmd.addr;
    pool_wdata = 32'd0;
    pool_re    = 1'b0;
    pool_raddr = cmd.addr;

    unique case (cmd.op)
      OP_CLEAR: begin
        mem_we  = 1'b1;
        pool_we = 1'b1;
        a_nxt   = 32'd0;
        b_nxt   = 32'd0;
        cnt_nxt = 32'd0;
      end
      OP_CAPTURE: word_nxt = word_in;
      OP_SEED_WR: begin
        pool_we    = 1'b1;
        pool_wdata = word_r;
      end
      OP_V_INIT: begin
        for (int e = 0; e < 8; e++) begin
          v_nxt[e] = GOLDEN;
        end
      end
      OP_SCRAMBLE: begin
        for (int e = 0; e < 8; e++) begin
          v_nxt[e] = w[(e + 1) % 8];
        end
      end
      OP_LOAD: begin
        mem_re  = cmd.rd_en & cmd.src_mem;
        pool_re = cmd.rd_en & ~cmd.src_mem;
        if (cmd.add_en) begin
          for (int e = 0; e < 7; e++) begin
            v_nxt[e] = v_r[e + 1];
          end
          v_nxt[7] = v_r[0] + ld_data;
        end
      end
      OP_V_WR: begin
        mem_we    = 1'b1;
        mem_wdata = v_r[0];
        for (int e = 0; e < 8; e++) begin
          v_nxt[e] = v_r[(e + 1) % 8];
        end
      end
      OP_RF_START: begin
        cnt_nxt = cnt_r + 32'd1;
        b_nxt   = b_r + cnt_r + 32'd1;
      end
      OP_RF0: mem_re = 1'b1;
      OP_RF1: begin
        x_nxt     = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = mem_rdata[IDX_W+1:2];
      end
      OP_RF2: begin
        s_nxt     = mem_rdata + b_r;
        mem_re    = 1'b1;
        mem_raddr = cmd.addr ^ IDX_W'(STATE_WORDS / 2);
      end
      OP_RF3: begin
        a_nxt     = a_calc;
        y_nxt     = y_calc;
        mem_we    = 1'b1;
        mem_wdata = y_calc;
        mem_re    = 1'b1;
        mem_raddr = y_calc[IDX_W+7:8];
        byp_nxt   = (y_calc[IDX_W+7:8] == cmd.addr);
      end
      OP_RF4: begin
        b_nxt      = b_calc;
        pool_we    = 1'b1;
        pool_wdata = b_calc;
      end
      OP_REQ_RD: pool_re = 1'b1;
      OP_OUT_LOAD: out_nxt = pool_rdata;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < 8; e++) begin
      v_r[e] <= v_nxt[e];
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    cnt_r  <= cnt_nxt;
    x_r    <= x_nxt;
    s_r    <= s_nxt;
    y_r    <= y_nxt;
    byp_r  <= byp_nxt;
    word_r <= word_nxt;
    out_r  <= out_nxt;
  end

  assign rand_value = out_r;

endmodule

// ===== hw/rtl/ip_ctrl.sv =====
// ----------------------------------------------------------------------------
// ip_ctrl - ISAAC controller
// Sequences clearing, seed loading, seeding, refills and requests, and
// drives the input and output handshakes.
// ----------------------------------------------------------------------------
module ip_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic               in_seed_last,
  output logic               out_valid,
  input  logic               out_stall,
  output isaac_pkg::ip_cmd_t cmd
);
  import isaac_pkg::*;

  ip_state_t        state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [3:0]       k_r, k_nxt;
  logic [4:0]       blk_r, blk_nxt;
  logic [1:0]       rnd_r, rnd_nxt;
  logic             pass_r, pass_nxt, from_req_r, from_req_nxt;
  logic             seed_r, seed_nxt, last_r, last_nxt, out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt, rem_r, rem_nxt;
  logic             accept, out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      k_r         <= '0;
      blk_r       <= '0;
      rnd_r       <= '0;
      pass_r      <= 1'b0;
      from_req_r  <= 1'b0;
      seed_r      <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      k_r         <= k_nxt;
      blk_r       <= blk_nxt;
      rnd_r       <= rnd_nxt;
      pass_r      <= pass_nxt;
      from_req_r  <= from_req_nxt;
      seed_r      <= seed_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      rem_r       <= rem_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_free  = ~out_valid_r | ~out_stall;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    blk_nxt       = blk_r;
    rnd_nxt       = rnd_r;
    pass_nxt      = pass_r;
    from_req_nxt  = from_req_r;
    seed_nxt      = seed_r;
    last_nxt      = last_r;
    pos_nxt       = pos_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd           = '{op: OP_NONE, addr: idx_r, ln: k_r[2:0],
                      rd_en: 1'b0, add_en: 1'b0, src_mem: pass_r};

    unique case (state_r)
      ST_CLEAR: begin
        cmd.op  = OP_CLEAR;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IDX_W'(STATE_WORDS - 1)) begin
          rem_nxt   = '0;
          state_nxt = seed_r ? ST_SEED_WR : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.op   = OP_CAPTURE;
          last_nxt = in_seed_last;
          if (in_mode) begin
            if (rem_r == '0) begin
              from_req_nxt = 1'b1;
              state_nxt    = ST_RF_START;
            end else begin
              state_nxt = ST_REQ_RD;
            end
          end else if (pos_r == '0) begin
            seed_nxt  = 1'b1;
            idx_nxt   = '0;
            state_nxt = ST_CLEAR;
          end else begin
            state_nxt = ST_SEED_WR;
          end
        end
      end
      ST_SEED_WR: begin
        seed_nxt = 1'b0;
        if (pos_r < CNT_W'(STATE_WORDS)) begin
          cmd.op   = OP_SEED_WR;
          cmd.addr = pos_r[IDX_W-1:0];
          pos_nxt  = pos_r + 1'b1;
        end
        if (last_r) begin
          pos_nxt      = '0;
          from_req_nxt = 1'b0;
          state_nxt    = ST_V_INIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_V_INIT: begin
        cmd.op    = OP_V_INIT;
        k_nxt     = '0;
        rnd_nxt   = '0;
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        cmd.op = OP_SCRAMBLE;
        k_nxt  = k_r + 1'b1;
        if (k_r == 4'd7) begin
          k_nxt   = '0;
          rnd_nxt = rnd_r + 1'b1;
          if (rnd_r == 2'd3) begin
            blk_nxt   = '0;
            pass_nxt  = 1'b0;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cmd.op     = OP_LOAD;
        cmd.addr   = {blk_r, k_r[2:0]};
        cmd.rd_en  = (k_r != 4'd8);
        cmd.add_en = (k_r != 4'd0);
        k_nxt      = k_r + 1'b1;
        if (k_r == 4'd8) begin
          k_nxt     = '0;
          state_nxt = ST_BSCR;
        end
      end
      ST_BSCR: begin
        cmd.op = OP_SCRAMBLE;
        k_nxt  = k_r + 1'b1;
        if (k_r == 4'd7) begin
          k_nxt     = '0;
          state_nxt = ST_VWR;
        end
      end
      ST_VWR: begin
        cmd.op   = OP_V_WR;
        cmd.addr = {blk_r, k_r[2:0]};
        k_nxt    = k_r + 1'b1;
        if (k_r == 4'd7) begin
          k_nxt   = '0;
          blk_nxt = blk_r + 1'b1;
          if (blk_r == 5'd31) begin
            if (pass_r) begin
              state_nxt = ST_RF_START;
            end else begin
              pass_nxt  = 1'b1;
              state_nxt = ST_LOAD;
            end
          end else begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_RF_START: begin
        cmd.op    = OP_RF_START;
        idx_nxt   = '0;
        state_nxt = ST_RF0;
      end
      ST_RF0: begin
        cmd.op    = OP_RF0;
        state_nxt = ST_RF1;
      end
      ST_RF1: begin
        cmd.op    = OP_RF1;
        state_nxt = ST_RF2;
      end
      ST_RF2: begin
        cmd.op    = OP_RF2;
        state_nxt = ST_RF3;
      end
      ST_RF3: begin
        cmd.op    = OP_RF3;
        state_nxt = ST_RF4;
      end
      ST_RF4: begin
        cmd.op    = OP_RF4;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ST_RF0;
        if (idx_r == IDX_W'(STATE_WORDS - 1)) begin
          rem_nxt   = CNT_W'(STATE_WORDS);
          state_nxt = from_req_r ? ST_REQ_RD : ST_IDLE;
        end
      end
      ST_REQ_RD: begin
        cmd.op    = OP_REQ_RD;
        cmd.addr  = IDX_W'(rem_r - 1'b1);
        rem_nxt   = rem_r - 1'b1;
        state_nxt = ST_REQ_OUT;
      end
      ST_REQ_OUT: begin
        if (out_free) begin
          cmd.op        = OP_OUT_LOAD;
          out_valid_nxt = 1'b1;
          from_req_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= CNT_W'(STATE_WORDS))
    else $error("pool count out of range");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= CNT_W'(STATE_WORDS))
    else $error("seed position out of range");

  a_req_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_REQ_RD |-> rem_r != '0)
    else $error("pool read while pool empty");

  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REQ_OUT && out_free) |=> out_valid_r)
    else $error("result word not presented");

endmodule

// ===== hw/rtl/isaac_prng.sv =====
// ----------------------------------------------------------------------------
// isaac_prng - ISAAC 32-bit pseudorandom word generator
// Seed loading, seeding and random word delivery over a 256-word state.
// ----------------------------------------------------------------------------
// After reset the block clears its two state memories and accepts no
// word meanwhile. A request that finds the pool empty first refills all
// 256 pool words, stepping through states RF0 to RF4 for each state word,
// as set by the single read port of the mixing memory. The first seed word
// of a load starts a clearing pass; the word marked last starts the seeding,
// scramble and memory passes followed by one refill. Results leave through
// an output register, so the next word is taken while a result still waits.
module isaac_prng (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [31:0] in_seed_word,
  input  logic        in_seed_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_rand_value
);
  import isaac_pkg::*;

  ip_cmd_t cmd;

  ip_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .in_seed_last(in_seed_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd)
  );

  ip_dp u_dp (
    .clk(clk), .cmd(cmd), .word_in(in_seed_word), .rand_value(out_rand_value)
  );

endmodule

// ===== tb/sv/isaac_prng_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// isaac_prng_tb - self-checking testbench of the ISAAC generator
// Seed loads and random word requests are driven through a pending queue
// with random gaps and receiver stalls. A behavioural copy of the generator
// predicts every random word, and the monitor compares each accepted word
// with the oldest prediction.
// ----------------------------------------------------------------------------
module isaac_prng_tb;

  import isaac_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct packed {
    logic        mode;
    logic [31:0] seed_word;
    logic        seed_last;
  } gen_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic [31:0] in_seed_word;
  logic        in_seed_last;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_rand_value;

  gen_item_t   pending_items[$];
  logic [31:0] expected_words[$];
  int          error_count;
  int          idle_cycles;
  bit          sender_hold;
  int          rx_hold_cycles;
  int          tx_gap;

  logic [31:0] mem_s[STATE_WORDS];
  logic [31:0] pool_s[STATE_WORDS];
  logic [31:0] aa_s;
  logic [31:0] bb_s;
  logic [31:0] cc_s;
  int          remaining_s;
  int          seed_pos_s;

  isaac_prng dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_seed_word(in_seed_word), .in_seed_last(in_seed_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_rand_value(out_rand_value)
  );

  always #6 clk = ~clk;

  task automatic clear_generator();
    for (int i = 0; i < STATE_WORDS; i++) begin
      mem_s[i]  = '0;
      pool_s[i] = '0;
    end
    aa_s = '0;
    bb_s = '0;
    cc_s = '0;
    remaining_s = 0;
  endtask

  task automatic scramble_lanes(ref logic [31:0] v[8]);
    v[0] ^= v[1] << 11; v[3] += v[0]; v[1] += v[2];
    v[1] ^= v[2] >> 2;  v[4] += v[1]; v[2] += v[3];
    v[2] ^= v[3] << 8;  v[5] += v[2]; v[3] += v[4];
    v[3] ^= v[4] >> 16; v[6] += v[3]; v[4] += v[5];
    v[4] ^= v[5] << 10; v[7] += v[4]; v[5] += v[6];
    v[5] ^= v[6] >> 4;  v[0] += v[5]; v[6] += v[7];
    v[6] ^= v[7] << 8;  v[1] += v[6]; v[7] += v[0];
    v[7] ^= v[0] >> 9;  v[2] += v[7]; v[0] += v[1];
  endtask

  task automatic refill_pool();
    logic [31:0] a, b, x, y, t;
    a = aa_s;
    cc_s = cc_s + 1;
    b = bb_s + cc_s;
    for (int i = 0; i < STATE_WORDS; i++) begin
      x = mem_s[i];
      case (i % 4)
        0: t = a << 13;
        1: t = a >> 6;
        2: t = a << 2;
        default: t = a >> 16;
      endcase
      a = (a ^ t) + mem_s[(i + STATE_WORDS / 2) % STATE_WORDS];
      y = mem_s[(x >> 2) % STATE_WORDS] + a + b;
      mem_s[i] = y;
      b = mem_s[(y >> 8) % STATE_WORDS] + x;
      pool_s[i] = b;
    end
    aa_s = a;
    bb_s = b;
    remaining_s = STATE_WORDS;
  endtask

  task automatic seed_generator();
    logic [31:0] v[8];
    for (int k = 0; k < 8; k++) v[k] = GOLDEN;
    for (int k = 0; k < 4; k++) scramble_lanes(v);
    for (int i = 0; i < STATE_WORDS; i += 8) begin
      for (int k = 0; k < 8; k++) v[k] += pool_s[i + k];
      scramble_lanes(v);
      for (int k = 0; k < 8; k++) mem_s[i + k] = v[k];
    end
    for (int i = 0; i < STATE_WORDS; i += 8) begin
      for (int k = 0; k < 8; k++) v[k] += mem_s[i + k];
      scramble_lanes(v);
      for (int k = 0; k < 8; k++) mem_s[i + k] = v[k];
    end
    refill_pool();
  endtask

  task automatic predict_word(input gen_item_t it);
    if (it.mode) begin
      if (remaining_s == 0) refill_pool();
      remaining_s--;
      expected_words.push_back(pool_s[remaining_s]);
    end else begin
      if (seed_pos_s == 0) clear_generator();
      if (seed_pos_s < STATE_WORDS) begin
        pool_s[seed_pos_s] = it.seed_word;
        seed_pos_s++;
      end
      if (it.seed_last) begin
        seed_generator();
        seed_pos_s = 0;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %08h, expected %08h", what, got, want);
    error_count++;
  endtask

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic gen_item_t make_item(input logic mode, input logic [31:0] w,
                                          input logic last);
    gen_item_t it;
    it.mode = mode;
    it.seed_word = w;
    it.seed_last = last;
    return it;
  endfunction

  task automatic push_seed_load(input int n, input bit random_words);
    for (int i = 0; i < n; i++)
      pending_items.push_back(make_item(1'b0,
        random_words ? $urandom() : 32'(i * 32'h01010101), i == n - 1));
  endtask

  task automatic push_requests(input int n);
    for (int i = 0; i < n; i++)
      pending_items.push_back(make_item(1'b1, $urandom(), $urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    sender_hold = 1'b1;
    while (expected_words.size() != 0) @(posedge clk);
    sender_hold = 1'b0;
  endtask

  // Driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else if (in_valid && !in_stall) begin
      predict_word(make_item(in_mode, in_seed_word, in_seed_last));
      if (pending_items.size() != 0 && !sender_hold && gap_length() == 0) begin
        {in_mode, in_seed_word, in_seed_last} <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
        tx_gap <= gap_length();
      end
    end else if (!in_valid) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
      end else if (pending_items.size() != 0 && !sender_hold) begin
        {in_mode, in_seed_word, in_seed_last} <= pending_items.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Monitor and receiver stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", out_rand_value, '0);
        end else begin
          logic [31:0] want;
          want = expected_words.pop_front();
          if (out_rand_value !== want) report_mismatch("rand_value", out_rand_value, want);
        end
      end
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles <= rx_hold_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (gap_length() != 0);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = 1'b0;
    in_seed_word = '0;
    in_seed_last = 1'b0;
    out_stall = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    sender_hold = 1'b0;
    rx_hold_cycles = 0;
    tx_gap = 0;
    seed_pos_s = 0;
    clear_generator();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Requests from the all-zero state, including a refill.
    push_requests(3);
    // Requests in the middle of a seed load, then the load completes.
    pending_items.push_back(make_item(1'b0, 32'h00000000, 1'b0));
    pending_items.push_back(make_item(1'b0, 32'hffffffff, 1'b0));
    push_requests(2);
    pending_items.push_back(make_item(1'b0, 32'h80000001, 1'b1));
    push_requests(4);
    // One-word load that is also the last.
    pending_items.push_back(make_item(1'b0, 32'h7fffffff, 1'b1));
    push_requests(3);
    wait_drained();

    // Long receiver hold while the sender keeps offering requests.
    rx_hold_cycles = 400;
    push_requests(40);
    wait_drained();

    // Oversized seed load: words beyond the pool size are dropped.
    push_seed_load(STATE_WORDS + 4, 1'b1);
    push_requests(300);
    wait_drained();

    for (int round = 0; round < 4; round++) begin
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) push_seed_load($urandom_range(1, 12), 1'b1);
      else if (r < 8) push_seed_load($urandom_range(1, 3), 1'b0);
      else push_seed_load(STATE_WORDS, 1'b1);
      push_requests($urandom_range(40, 120));
      if ($urandom_range(0, 3) == 0) begin
        pending_items.push_back(make_item(1'b0, $urandom(), 1'b0));
        push_requests(3);
        pending_items.push_back(make_item(1'b0, $urandom(), 1'b1));
      end
      wait_drained();
    end

    repeat (50) @(posedge clk);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
